@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the wildcard byte pattern search.
// Depends on nothing; simulation builds get the checks, SYNTH builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/wbps_pkg.sv @@
// Package of the wildcard byte pattern search: constants, register codes and
// the configuration struct. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

  localparam int MaxPatternDefault = 16;
  localparam int OffsetBitsDefault = 32;
  localparam int CfgDataW          = 64;
  localparam int CfgIdxW           = 2;
  localparam int PatRegBytes       = 16;
  localparam int RawLenW           = 5;
  localparam int OffsetOutW        = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_CARE_MASK      = 2'd2,
    REG_PATTERN_LENGTH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PatRegBytes-1:0][7:0] pattern;
    logic [PatRegBytes-1:0]      care;
    logic [RawLenW-1:0]          length;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/wbps_cfg_regs.sv @@
// Configuration register file of the wildcard byte pattern search.
// Depends on wbps_pkg for the register codes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module wbps_cfg_regs import wbps_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  logic [CfgDataW-1:0]    pat_lo_q, pat_lo_d;
  logic [CfgDataW-1:0]    pat_hi_q, pat_hi_d;
  logic [PatRegBytes-1:0] care_q, care_d;
  logic [RawLenW-1:0]     len_q, len_d;

  always_comb begin
    pat_lo_d = pat_lo_q;
    pat_hi_d = pat_hi_q;
    care_d   = care_q;
    len_d    = len_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PATTERN_LOW:    pat_lo_d = cfg_data_i;
        REG_PATTERN_HIGH:   pat_hi_d = cfg_data_i;
        REG_CARE_MASK:      care_d   = cfg_data_i[PatRegBytes-1:0];
        REG_PATTERN_LENGTH: len_d    = cfg_data_i[RawLenW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '1;
      len_q    <= RawLenW'(1);
    end else begin
      pat_lo_q <= pat_lo_d;
      pat_hi_q <= pat_hi_d;
      care_q   <= care_d;
      len_q    <= len_d;
    end
  end

  assign cfg_o.pattern = {pat_hi_q, pat_lo_q};
  assign cfg_o.care    = care_q;
  assign cfg_o.length  = len_q;

endmodule

`default_nettype wire

@@ rtl/wbps_matcher.sv @@
// Window compare of the wildcard byte pattern search: effective length, fill
// check and the parallel compare of all pattern positions. Depends on wbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbps_matcher import wbps_pkg::*; #(
  parameter  int MAX_PATTERN = MaxPatternDefault,
  localparam int LenW        = $clog2(MAX_PATTERN + 1),
  localparam int IdxW        = $clog2(MAX_PATTERN)
) (
  input  wire cfg_t                         cfg_i,
  input  wire logic [7:0]                   data_i,
  input  wire logic [MAX_PATTERN-2:0][7:0]  window_i,
  input  wire logic [LenW-1:0]              fill_i,
  output logic      [LenW-1:0]              fill_next_o,
  output logic      [LenW-1:0]              len_o,
  output logic                              hit_o
);

  logic [MAX_PATTERN-1:0][7:0] w_all;
  logic [MAX_PATTERN-1:0][7:0] pat_ext;
  logic [MAX_PATTERN-1:0]      care_ext;
  logic                        bytes_ok;

  assign w_all = {window_i, data_i};

  // Position zero is always cared; positions without register bits are wildcards.
  for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_pos
    if (p == 0) begin : g_first
      assign care_ext[p] = 1'b1;
      assign pat_ext[p]  = cfg_i.pattern[0];
    end else if (p < PatRegBytes) begin : g_reg
      assign care_ext[p] = cfg_i.care[p];
      assign pat_ext[p]  = cfg_i.pattern[p];
    end else begin : g_wild
      assign care_ext[p] = 1'b0;
      assign pat_ext[p]  = 8'h00;
    end
  end

  always_comb begin
    if (cfg_i.length == '0) begin
      len_o = LenW'(1);
    end else if (int'(cfg_i.length) > MAX_PATTERN) begin
      len_o = LenW'(MAX_PATTERN);
    end else begin
      len_o = LenW'(cfg_i.length);
    end
  end

  assign fill_next_o = (int'(fill_i) == MAX_PATTERN) ? fill_i : fill_i + LenW'(1);

  always_comb begin
    int idx;
    bytes_ok = 1'b1;
    idx      = 0;
    for (int p = 0; p < MAX_PATTERN; p++) begin
      if (p < int'(len_o)) begin
        idx = int'(len_o) - 1 - p;
        if (care_ext[p] && (w_all[idx[IdxW-1:0]] != pat_ext[p])) begin
          bytes_ok = 1'b0;
        end
      end
    end
  end

  assign hit_o = bytes_ok && (fill_next_o >= len_o);

endmodule

`default_nettype wire

@@ rtl/wildcard_byte_pattern_search.sv @@
// Top level of the wildcard byte pattern search: input register, region state,
// result register and checks. Depends on wbps_pkg, wbps_cfg_regs, wbps_matcher.
//
// Usage: the region to scan arrives on the input channel one byte per item,
// with last_byte_i marking its final byte. For each region the block returns
// at most one item on the output channel: found with the start offset of the
// lowest matching position, or not-found with offset zero when the region ends
// without a match. After a match the remaining bytes of the region give no item.
// Both channels use valid and stall; an item moves when valid is high and stall
// is low. The configuration port writes the pattern, care mask and length by
// register index and should be used only while no region is in progress.
// A result enters the result register when the byte that decides it leaves
// the input register, which it can do only when the output is free.
// Throughput is one byte per cycle while the receiver does not stall; the window
// compare is one combinational stage between the input and result registers.
// While the receiver stalls with a result pending, one further byte is held in
// the input register and the input is stalled. Reset empties both registers,
// clears the window and restores the default configuration.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wildcard_byte_pattern_search import wbps_pkg::*; #(
  parameter int MAX_PATTERN = MaxPatternDefault,
  parameter int OFFSET_BITS = OffsetBitsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  last_byte_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       found_o,
  output logic [OffsetOutW-1:0]      match_offset_o
);

  localparam int LenW = $clog2(MAX_PATTERN + 1);

  cfg_t cfg;

  logic                        s1_valid_q, s1_valid_d;
  logic [7:0]                  s1_data_q, s1_data_d;
  logic                        s1_last_q, s1_last_d;
  logic                        s1_go;
  logic                        in_take;

  logic [MAX_PATTERN-2:0][7:0] win_q, win_d;
  logic [LenW-1:0]             fill_q, fill_d, fill_next;
  logic [OFFSET_BITS-1:0]      seen_q, seen_d, seen_next, start;
  logic                        reported_q, reported_d;
  logic [LenW-1:0]             len_eff;
  logic                        hit;

  logic                        out_valid_q, out_valid_d;
  logic                        found_q, found_d;
  logic [OffsetOutW-1:0]       offset_q, offset_d;
  logic [OFFSET_BITS+OffsetOutW-1:0] start_ext;

  wbps_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  wbps_matcher #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_matcher (
    .cfg_i      (cfg),
    .data_i     (s1_data_q),
    .window_i   (win_q),
    .fill_i     (fill_q),
    .fill_next_o(fill_next),
    .len_o      (len_eff),
    .hit_o      (hit)
  );

  assign s1_go      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_take    = in_valid_i && !in_stall_o;

  assign seen_next = seen_q + OFFSET_BITS'(1);
  assign start     = seen_next - OFFSET_BITS'(len_eff);
  assign start_ext = {{OffsetOutW{1'b0}}, start};

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_data_d  = s1_data_q;
    s1_last_d  = s1_last_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
      s1_data_d  = data_byte_i;
      s1_last_d  = last_byte_i;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    seen_d      = seen_q;
    reported_d  = reported_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    offset_d    = offset_q;
    if (s1_go) begin
      if (!reported_q) begin
        win_d[0] = s1_data_q;
        for (int k = 1; k < MAX_PATTERN - 1; k++) begin
          win_d[k] = win_q[k-1];
        end
        fill_d = fill_next;
        seen_d = seen_next;
        if (hit) begin
          reported_d  = 1'b1;
          out_valid_d = 1'b1;
          found_d     = 1'b1;
          offset_d    = start_ext[OffsetOutW-1:0];
        end else if (s1_last_q) begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          offset_d    = '0;
        end
      end
      if (s1_last_q) begin
        win_d      = '0;
        fill_d     = '0;
        seen_d     = '0;
        reported_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      win_q       <= '0;
      fill_q      <= '0;
      seen_q      <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      win_q       <= win_d;
      fill_q      <= fill_d;
      seen_q      <= seen_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_data_q <= s1_data_d;
    s1_last_q <= s1_last_d;
    found_q   <= found_d;
    offset_q  <= offset_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

  `ASSERT_IMPL(a_notfound_zero, clk_i, rst_ni, out_valid_q && !found_q, offset_q == '0)
  `ASSERT_NEXT(a_quiet_after_match, clk_i, rst_ni, s1_go && reported_q, !out_valid_q)
  `ASSERT_NEXT(a_region_end_clears, clk_i, rst_ni, s1_go && s1_last_q,
               fill_q == '0 && seen_q == '0 && !reported_q)
  `ASSERT_IMPL(a_stall_holds_item, clk_i, rst_ni, in_stall_o, s1_valid_q && out_valid_q)

endmodule

`default_nettype wire
